[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the stereo decimator rtl, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define SDCR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define SDCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SDCR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SDCR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/sdcr_pkg.sv]
// ----------------------------------------------------------------------------
// sdcr_pkg
// shared types, constants and the crossfeed mix function
// ----------------------------------------------------------------------------
package sdcr_pkg;

    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SAMPLE_W        = 16;
    localparam int FILT_W          = 14;
    localparam int CFG_W           = 13;
    localparam logic [CFG_W-1:0] MIN_DELAY = 13'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } frame_t;

    // (3*own + other) >> 2, floor; the result always fits 16 bits
    function automatic logic signed [SAMPLE_W-1:0] mix3(
        input logic signed [SAMPLE_W-1:0] own,
        input logic signed [SAMPLE_W-1:0] other
    );
        logic signed [SAMPLE_W+1:0] acc;
        acc = {{2{own[SAMPLE_W-1]}}, own}
            + {own[SAMPLE_W-1], own, 1'b0}
            + {{2{other[SAMPLE_W-1]}}, other};
        return acc[SAMPLE_W+1:2];
    endfunction

endpackage

[hw/rtl/sdcr_front.sv]
// ----------------------------------------------------------------------------
// sdcr_front
// 2:1 decimation and crossfeed, one odd-phase frame yields one mixed frame
// ----------------------------------------------------------------------------
module sdcr_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_fire,
    input  logic signed [sdcr_pkg::SAMPLE_W-1:0]   left_in,
    input  logic signed [sdcr_pkg::SAMPLE_W-1:0]   right_in,
    input  logic                                   block_end,
    output logic                                   odd_phase,
    output sdcr_pkg::frame_t                       mix
);

    localparam int SW = sdcr_pkg::SAMPLE_W;
    localparam int FW = sdcr_pkg::FILT_W;

    logic                 phase_reg;
    logic signed [FW-1:0] filt_l_reg, filt_r_reg;
    logic signed [SW-1:0] part_l_reg, part_r_reg;
    logic signed [FW-1:0] quart_l, quart_r;
    logic signed [SW-1:0] half_l, half_r;
    logic signed [SW-1:0] dec_l, dec_r;

    assign quart_l = left_in[SW-1:2];
    assign quart_r = right_in[SW-1:2];
    assign half_l  = {left_in[SW-1], left_in[SW-1:1]};
    assign half_r  = {right_in[SW-1], right_in[SW-1:1]};

    // odd frame closes the pair
    assign dec_l = part_l_reg + {{(SW-FW){quart_l[FW-1]}}, quart_l};
    assign dec_r = part_r_reg + {{(SW-FW){quart_r[FW-1]}}, quart_r};

    assign odd_phase  = phase_reg;
    assign mix.left   = sdcr_pkg::mix3(dec_l, dec_r);
    assign mix.right  = sdcr_pkg::mix3(dec_r, dec_l);
    assign mix.last   = block_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 1'b0;
            filt_l_reg <= '0;
            filt_r_reg <= '0;
            part_l_reg <= '0;
            part_r_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= ~phase_reg;
            if (phase_reg) begin
                filt_l_reg <= quart_l;
                filt_r_reg <= quart_r;
            end else begin
                part_l_reg <= {{(SW-FW){filt_l_reg[FW-1]}}, filt_l_reg} + half_l;
                part_r_reg <= {{(SW-FW){filt_r_reg[FW-1]}}, filt_r_reg} + half_r;
            end
        end
    end

endmodule

[hw/rtl/stereo_decimate_crossfeed_reverb.sv]
// ----------------------------------------------------------------------------
// stereo_decimate_crossfeed_reverb
// stereo 2:1 decimator with crossfeed and a cross-delay feedback ring
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata = left_in, right_in; tlast = block_end
//  m_        out  m_tvalid/m_tready    tdata = left_out, right_out; tlast = block_last
//  cfg_      in   cfg_wr_en            cfg_wr_data = delay_frames
//
//  one input transfer per cycle while the output is not stalled; one result per two inputs
//  result of an odd frame passes the delay stage, then the output register
//  (mix and ring read into the delay stage, then ring modify/write into the output register)
//  reset is synchronous; the ring reads as zero until written, tracked by a
//  fill count, so no clearing pass is needed
//  a stalled output holds the delay stage; even frames are always taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_decimate_crossfeed_reverb #(
    parameter int DELAY_DEPTH = sdcr_pkg::DELAY_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,    // left_in [15:0], right_in [31:16]
    input  logic                        s_tlast,    // block_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,    // left_out [15:0], right_out [31:16]
    output logic                        m_tlast,    // block_last
    input  logic                        cfg_wr_en,
    input  logic [sdcr_pkg::CFG_W-1:0]  cfg_wr_data // delay_frames
);

    localparam int SW    = sdcr_pkg::SAMPLE_W;
    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int CNT_W = $clog2(DELAY_DEPTH + 1);
    localparam int LIM_W = (CNT_W > sdcr_pkg::CFG_W) ? CNT_W : sdcr_pkg::CFG_W;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DELAY_DEPTH);

    // configuration
    logic [sdcr_pkg::CFG_W-1:0] delay_frames_reg;

    // front end
    logic             s_fire;
    logic             odd_phase;
    logic             odd_fire;
    sdcr_pkg::frame_t mix;

    // ring control
    logic [AW-1:0]    idx_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             delay_on;
    logic [LIM_W-1:0] frames_ext, limit, idx_inc;

    // delay stage, paired with the ring read in flight
    logic             s1_valid_reg;
    logic             s1_delay_reg;
    logic             s1_hit_reg;
    logic [AW-1:0]    s1_idx_reg;
    sdcr_pkg::frame_t s1_frame_reg;
    logic             s1_move;

    // ring store, left in the low half, right in the high half
    logic [2*SW-1:0]  ring_mem [DELAY_DEPTH];
    logic [2*SW-1:0]  rd_word_reg;
    logic [2*SW-1:0]  old_word;
    logic signed [SW-1:0] new_l, new_r;
    logic             ring_wr;

    // output register
    logic             m_valid_reg;
    logic [2*SW-1:0]  m_data_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_frames_reg <= '0;
        end else if (cfg_wr_en) begin
            delay_frames_reg <= cfg_wr_data;
        end
    end

    sdcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_fire),
        .left_in   (s_tdata[SW-1:0]),
        .right_in  (s_tdata[2*SW-1:SW]),
        .block_end (s_tlast),
        .odd_phase (odd_phase),
        .mix       (mix)
    );

    // the delay stage frees up when its result can move to the output
    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !odd_phase || !s1_valid_reg || s1_move;
    assign s_fire   = s_tvalid && s_tready;
    assign odd_fire = s_fire && odd_phase;

    // active length clamps to the store depth
    assign delay_on   = delay_frames_reg >= sdcr_pkg::MIN_DELAY;
    assign frames_ext = LIM_W'(delay_frames_reg);
    assign limit      = (frames_ext > DEPTH_L) ? DEPTH_L : frames_ext;
    assign idx_inc    = LIM_W'(idx_reg) + LIM_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            fill_reg <= '0;
        end else if (odd_fire && delay_on) begin
            // wrap also covers a length shortened while idle
            idx_reg <= (idx_inc >= limit) ? '0 : idx_inc[AW-1:0];
            // written entries always form a prefix of the store
            if (idx_inc > LIM_W'(fill_reg)) begin
                fill_reg <= idx_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (odd_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (odd_fire) begin
            s1_delay_reg <= delay_on;
            s1_hit_reg   <= LIM_W'(idx_reg) < LIM_W'(fill_reg);
            s1_idx_reg   <= idx_reg;
            s1_frame_reg <= mix;
        end
    end

    // never-written entries read as zero
    assign old_word = s1_hit_reg ? rd_word_reg : '0;
    assign new_l    = sdcr_pkg::mix3(s1_frame_reg.left,  old_word[2*SW-1:SW]);
    assign new_r    = sdcr_pkg::mix3(s1_frame_reg.right, old_word[SW-1:0]);
    assign ring_wr  = s1_move && s1_delay_reg;

    // read of the next entry and write-back of the current one hit different
    // addresses, as the active length is at least two
    always_ff @(posedge aclk) begin
        if (odd_fire && delay_on) begin
            rd_word_reg <= ring_mem[idx_reg];
        end
        if (ring_wr) begin
            ring_mem[s1_idx_reg] <= {new_r, new_l};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_data_reg <= s1_delay_reg ? {new_r, new_l}
                                       : {s1_frame_reg.right, s1_frame_reg.left};
            m_last_reg <= s1_frame_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `SDCR_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, LIM_W'(fill_reg) <= DEPTH_L)
    `SDCR_ASSERT_IMP(a_ring_read_in_prefix, aclk, aresetn, s1_valid_reg && s1_delay_reg, LIM_W'(s1_idx_reg) < LIM_W'(fill_reg))
    `SDCR_ASSERT_NXT(a_phase_toggles, aclk, aresetn, s_fire, odd_phase != $past(odd_phase))
    `SDCR_ASSERT_NXT(a_out_from_stage, aclk, aresetn, !m_valid_reg && !s1_valid_reg, !m_valid_reg)

endmodule
